FILE: sv/pol_pkg.sv
// shared constants, request and status codes and the cell command type
// for the positional ordered list; no dependencies
package pol_pkg;

   localparam int POL_CAPACITY = 16;
   localparam int DATA_W       = 32;

   typedef logic [2:0]              req_kind_type;
   typedef logic [1:0]              status_type;
   typedef logic [2:0]              cell_op_type;
   typedef logic signed [DATA_W-1:0] data_type;

   // request kinds
   localparam req_kind_type REQ_ADD_FRONT = 3'd0;
   localparam req_kind_type REQ_ADD_BACK  = 3'd1;
   localparam req_kind_type REQ_ADD_AT    = 3'd2;
   localparam req_kind_type REQ_UPDATE    = 3'd3;
   localparam req_kind_type REQ_DEL_FRONT = 3'd4;
   localparam req_kind_type REQ_DEL_BACK  = 3'd5;
   localparam req_kind_type REQ_DEL_AT    = 3'd6;
   localparam req_kind_type REQ_READ_ALL  = 3'd7;

   // result status
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_EMPTY   = 2'd2;
   localparam status_type ST_FULL    = 2'd3;

   // per-cycle command broadcast to every cell
   localparam cell_op_type CELL_HOLD = 3'd0;
   localparam cell_op_type CELL_INS  = 3'd1;
   localparam cell_op_type CELL_DEL  = 3'd2;
   localparam cell_op_type CELL_UPD  = 3'd3;
   localparam cell_op_type CELL_ROT  = 3'd4;

   typedef struct packed {
      cell_op_type op;
      data_type    value;
   } cell_cmd_type;

endpackage

FILE: sv/pol_intf.sv
// valid/ready channel interfaces for the request and result beats
// depends on pol_pkg
interface pol_req_if;
   import pol_pkg::*;
   logic         valid;
   logic         ready;
   req_kind_type req_type;
   data_type     value;
   logic [4:0]   position;

   modport source (output valid, req_type, value, position, input ready);
   modport sink   (input valid, req_type, value, position, output ready);
endinterface

interface pol_rsp_if;
   import pol_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   data_type   element;
   logic [3:0] index;
   logic [4:0] count;
   logic       last;

   modport source (output valid, status, element, index, count, last, input ready);
   modport sink   (input valid, status, element, index, count, last, output ready);
endinterface

FILE: sv/positional_ordered_list.sv
// top level of the positional ordered list: request decode, read-out
// sequencing, result register and the chain of cells
// depends on pol_pkg, pol_intf (pol_req_if, pol_rsp_if) and pol_cell
//
// A bounded ordered list of signed 32-bit elements, kept in a row of
// CAPACITY cells where cell 0 is the front. Every edit (insert at front,
// back or position, update, delete at front, back or position) is decoded
// in the cycle its beat is accepted and all cells move at once, and an
// edit gives one result beat. A read-out gives one beat per
// element (an empty list gives a single beat with status empty); the chain
// rotates one place per beat, presenting the next element at cell 0 and
// moving the old head to the tail, so after count beats the list is back
// in order. A read-out holds off the request side until its last beat has
// been given. Results sit in a single output register, and a new request
// is taken when no read-out is running and that register is empty or
// being emptied in the same cycle. Inserts into a full list return status
// full; positions are checked before fullness for positional inserts.
module positional_ordered_list #(
   parameter int CAPACITY = pol_pkg::POL_CAPACITY
) (
   input logic         clock,
   input logic         reset,
   pol_req_if.sink     req,
   pol_rsp_if.source   rsp
);
   import pol_pkg::*;

   localparam int CW   = $clog2(CAPACITY+1);   // count width
   localparam int IW   = $clog2(CAPACITY);     // element index width
   localparam int WIDE = CW + 5;               // compare / masking width
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   // control state
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // result payload
   status_type    status_ff, status_in;
   data_type      element_ff, element_in;
   logic [3:0]    index_ff, index_in;
   logic [4:0]    rsp_count_ff, rsp_count_in;
   logic          last_ff, last_in;

   // chain wiring
   data_type      cell_q [CAPACITY];
   cell_cmd_type  cmd;
   logic [CW-1:0] cmd_pos;

   // decode results
   status_type    dec_status;
   cell_op_type   dec_op;
   logic [CW-1:0] dec_pos;
   logic [CW-1:0] dec_count;
   logic          dec_start_rd;

   logic          slot_free;
   logic          req_acc;
   logic          rd_step;
   logic          rd_last;
   logic          full;
   logic          empty;
   logic          pos_le_cnt;
   logic          pos_lt_cnt;
   logic [WIDE-1:0] pos_wide;
   logic [WIDE-1:0] cnt_wide;
   logic [WIDE-1:0] idx_wide;
   logic [WIDE-1:0] cnt_out_wide;

   // handshake: output register parts the two sides
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = !busy_ff && slot_free;
   assign req_acc   = req.valid && req.ready;
   assign rd_step   = busy_ff && slot_free;
   assign rd_last   = (CW'(rd_idx_ff) + ONE_C) == count_ff;

   assign full     = count_ff == CAP_C;
   assign empty    = count_ff == '0;
   assign pos_wide = WIDE'(req.position);
   assign cnt_wide = WIDE'(count_ff);
   assign pos_le_cnt = pos_wide <= cnt_wide;
   assign pos_lt_cnt = pos_wide < cnt_wide;

   // request decode
   always_comb begin
      dec_status   = ST_OK;
      dec_op       = CELL_HOLD;
      dec_pos      = '0;
      dec_count    = count_ff;
      dec_start_rd = 1'b0;
      case (req.req_type)
         REQ_ADD_FRONT: begin
            if (full) dec_status = ST_FULL;
            else begin
               dec_op    = CELL_INS;
               dec_count = count_ff + ONE_C;
            end
         end
         REQ_ADD_BACK: begin
            if (full) dec_status = ST_FULL;
            else begin
               dec_op    = CELL_INS;
               dec_pos   = count_ff;
               dec_count = count_ff + ONE_C;
            end
         end
         REQ_ADD_AT: begin
            if (!pos_le_cnt) dec_status = ST_INVALID;
            else if (full) dec_status = ST_FULL;
            else begin
               dec_op    = CELL_INS;
               dec_pos   = CW'(req.position);
               dec_count = count_ff + ONE_C;
            end
         end
         REQ_UPDATE: begin
            if (!pos_lt_cnt) dec_status = ST_INVALID;
            else begin
               dec_op  = CELL_UPD;
               dec_pos = CW'(req.position);
            end
         end
         REQ_DEL_FRONT: begin
            if (empty) dec_status = ST_EMPTY;
            else begin
               dec_op    = CELL_DEL;
               dec_count = count_ff - ONE_C;
            end
         end
         REQ_DEL_BACK: begin
            if (empty) dec_status = ST_EMPTY;
            else begin
               dec_op    = CELL_DEL;
               dec_pos   = count_ff - ONE_C;
               dec_count = count_ff - ONE_C;
            end
         end
         REQ_DEL_AT: begin
            if (!pos_lt_cnt) dec_status = ST_INVALID;
            else begin
               dec_op    = CELL_DEL;
               dec_pos   = CW'(req.position);
               dec_count = count_ff - ONE_C;
            end
         end
         REQ_READ_ALL: begin
            if (empty) dec_status = ST_EMPTY;
            else dec_start_rd = 1'b1;
         end
         default: dec_status = ST_OK;
      endcase
   end

   // command broadcast: read-out rotation wins, it only runs while busy
   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.value = req.value;
      cmd_pos   = dec_pos;
      if (rd_step) begin
         cmd.op    = CELL_ROT;
         cmd.value = cell_q[0];
      end else if (req_acc) begin
         cmd.op = dec_op;
      end
   end

   // next state and result beat
   always_comb begin
      count_in     = count_ff;
      busy_in      = busy_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      element_in   = element_ff;
      index_in     = index_ff;
      rsp_count_in = rsp_count_ff;
      last_in      = last_ff;
      idx_wide     = WIDE'(rd_idx_ff);
      cnt_out_wide = WIDE'(count_ff);
      if (rd_step) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         element_in   = cell_q[0];
         index_in     = idx_wide[3:0];
         rsp_count_in = cnt_out_wide[4:0];
         last_in      = rd_last;
         rd_idx_in    = rd_idx_ff + IW'(1);
         if (rd_last) begin
            busy_in   = 1'b0;
            rd_idx_in = '0;
         end
      end else if (req_acc) begin
         if (dec_start_rd) begin
            busy_in   = 1'b1;
            rd_idx_in = '0;
         end else begin
            cnt_out_wide = WIDE'(dec_count);
            count_in     = dec_count;
            rsp_valid_in = 1'b1;
            status_in    = dec_status;
            element_in   = '0;
            index_in     = '0;
            rsp_count_in = cnt_out_wide[4:0];
            last_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      element_ff   <= element_in;
      index_ff     <= index_in;
      rsp_count_ff <= rsp_count_in;
      last_ff      <= last_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = status_ff;
   assign rsp.element = element_ff;
   assign rsp.index   = index_ff;
   assign rsp.count   = rsp_count_ff;
   assign rsp.last    = last_ff;

   // the chain: each cell sees its neighbours, ends tied off
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type left_d;
      data_type right_d;
      if (i == 0) begin : g_head
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_q[i-1];
      end
      if (i == CAPACITY-1) begin : g_tail
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_q[i+1];
      end
      pol_cell #(
         .CAPACITY (CAPACITY),
         .IDX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (cmd_pos),
         .count      (count_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_q[i])
      );
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("list count beyond capacity");

   a_rd_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (CW'(rd_idx_ff) < count_ff))
      else $error("read-out index beyond list count");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.ready)
      else $error("request taken during read-out");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_FULL) |-> full)
      else $error("full status with room in the list");

   a_count_holds_in_rd: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && busy_in) |=> $stable(count_ff))
      else $error("count changed during read-out");

endmodule

FILE: sv/pol_cell.sv
// one storage cell of the list chain: holds one element and takes its
// next value from itself, a neighbour or the broadcast; depends on pol_pkg
module pol_cell #(
   parameter int CAPACITY = pol_pkg::POL_CAPACITY,
   parameter int IDX      = 0
) (
   input  logic                              clock,
   input  pol_pkg::cell_cmd_type             cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]     pos,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  pol_pkg::data_type                 left_data,
   input  pol_pkg::data_type                 right_data,
   output pol_pkg::data_type                 data
);
   import pol_pkg::*;

   localparam int CW = $clog2(CAPACITY+1);
   localparam logic [CW-1:0] IDX_C  = CW'(IDX);
   localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);

   data_type data_ff;
   data_type data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INS: begin
            if (IDX_C > pos) data_in = left_data;
            else if (IDX_C == pos) data_in = cmd.value;
         end
         CELL_DEL: begin
            if (IDX_C >= pos) data_in = right_data;
         end
         CELL_UPD: begin
            if (IDX_C == pos) data_in = cmd.value;
         end
         CELL_ROT: begin
            // head value re-enters at the tail
            if (IDX1_C < count) data_in = right_data;
            else if (IDX1_C == count) data_in = cmd.value;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: dv/positional_ordered_list_test.sv
// self-checking test of positional_ordered_list: request and result beats on
// valid/ready channels, results checked against a shadow list kept here
// depends on pol_pkg, pol_intf (pol_req_if, pol_rsp_if) and positional_ordered_list
module positional_ordered_list_test;
   import pol_pkg::*;

   localparam int RANDOM_ITEMS = 181;
   localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on either side
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 80;     // receiver hold-off that backs the block up

   typedef struct packed {
      req_kind_type kind;
      data_type     value;
      logic [4:0]   position;
   } list_req_type;

   typedef struct packed {
      status_type status;
      data_type   element;
      logic [3:0] index;
      logic [4:0] count;
      logic       last;
   } list_rsp_type;

   logic clock;
   logic reset;

   pol_req_if req_ch ();
   pol_rsp_if rsp_ch ();

   positional_ordered_list i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // stimulus not yet offered, and the model's view of the list
   list_req_type request_backlog[$];
   data_type     shadow_list[$];
   list_rsp_type awaited_results[$];

   int  gen_count;          // list length the stimulus generator expects
   int  requests_taken;
   int  mismatches;
   int  req_gap;
   int  rsp_hold;
   int  beats_offered;
   int  rsp_cycles;
   bit  req_fired;
   bit  calm_req;
   bit  calm_rsp;
   bit  hold_off_wanted;

   // clock: period of 2
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // idle length after a beat: mostly none, some short, a few long
   function automatic int pick_gap(bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // queue one request and track the length it will leave behind, so that
   // random positions can be aimed mostly at the valid range
   function automatic void queue_request(req_kind_type kind, data_type v, logic [4:0] pos);
      list_req_type item;
      item = '{kind: kind, value: v, position: pos};
      request_backlog.push_back(item);
      case (kind)
         REQ_ADD_FRONT, REQ_ADD_BACK: begin
            if (gen_count < POL_CAPACITY) gen_count++;
         end
         REQ_ADD_AT: begin
            if (pos <= gen_count && gen_count < POL_CAPACITY) gen_count++;
         end
         REQ_DEL_FRONT, REQ_DEL_BACK: begin
            if (gen_count > 0) gen_count--;
         end
         REQ_DEL_AT: begin
            if (pos < gen_count) gen_count--;
         end
         default: ;
      endcase
   endfunction

   // apply one accepted request to the shadow list and queue the result
   // beats it must produce
   function automatic void apply_list_request(req_kind_type kind, data_type v,
                                              logic [4:0] pos);
      list_rsp_type outcome;
      int n;
      n = shadow_list.size();
      outcome = '{status: ST_OK, element: '0, index: '0, count: '0, last: 1'b1};
      case (kind)
         REQ_ADD_FRONT: begin
            if (n >= POL_CAPACITY) outcome.status = ST_FULL;
            else shadow_list.push_front(v);
         end
         REQ_ADD_BACK: begin
            if (n >= POL_CAPACITY) outcome.status = ST_FULL;
            else shadow_list.push_back(v);
         end
         REQ_ADD_AT: begin
            // position is judged before fullness
            if (pos > n) outcome.status = ST_INVALID;
            else if (n >= POL_CAPACITY) outcome.status = ST_FULL;
            else shadow_list.insert(int'(pos), v);
         end
         REQ_UPDATE: begin
            if (pos >= n) outcome.status = ST_INVALID;
            else shadow_list[pos] = v;
         end
         REQ_DEL_FRONT: begin
            if (n == 0) outcome.status = ST_EMPTY;
            else void'(shadow_list.pop_front());
         end
         REQ_DEL_BACK: begin
            if (n == 0) outcome.status = ST_EMPTY;
            else void'(shadow_list.pop_back());
         end
         REQ_DEL_AT: begin
            if (pos >= n) outcome.status = ST_INVALID;
            else shadow_list.delete(int'(pos));
         end
         default: begin
            // read-out: one beat per element, or a single empty beat
            if (n == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < n; i++) begin
                  outcome.element = shadow_list[i];
                  outcome.index   = 4'(i);
                  outcome.count   = 5'(n);
                  outcome.last    = (i == n - 1);
                  awaited_results.push_back(outcome);
               end
               return;
            end
         end
      endcase
      outcome.count = 5'(shadow_list.size());
      awaited_results.push_back(outcome);
   endfunction

   task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
         mismatches++;
      end
   endtask

   // request driver: a new beat goes out at the falling edge once the old one
   // was taken, with random gaps between beats
   always @(negedge clock) begin : drive_requests
      list_req_type item;
      if (!reset && (!req_ch.valid || req_fired)) begin
         if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap--;
         end else if (request_backlog.size() != 0) begin
            item = request_backlog.pop_front();
            req_ch.req_type <= item.kind;
            req_ch.value    <= item.value;
            req_ch.position <= item.position;
            req_ch.valid    <= 1'b1;
            beats_offered++;
            // every 20 beats decide whether the next stretch runs without gaps
            if (beats_offered % 20 == 0) calm_req = ($urandom_range(0, 3) == 0);
            req_gap = pick_gap(calm_req);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, plus one long hold-off on request so the
   // output register fills and the request side backs up
   always @(negedge clock) begin : drive_ready
      if (!reset) begin
         rsp_cycles++;
         if (rsp_cycles % 64 == 0) calm_rsp = ($urandom_range(0, 3) == 0);
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            rsp_hold = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_hold = pick_gap(calm_rsp);
            if (rsp_hold == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               rsp_hold--;
            end
         end
      end
   end

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin : watch_beats
      list_rsp_type got;
      list_rsp_type want;
      req_fired = !reset && req_ch.valid && req_ch.ready;
      if (req_fired) begin
         apply_list_request(req_ch.req_type, req_ch.value, req_ch.position);
         requests_taken++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{status: rsp_ch.status, element: rsp_ch.element, index: rsp_ch.index,
                 count: rsp_ch.count, last: rsp_ch.last};
         if (awaited_results.size() == 0) begin
            $display("%0t: result beat with none awaited, expected nothing, got %h",
                     $time, got);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status",  32'(want.status), 32'(got.status));
            check_field("element", want.element,     got.element);
            check_field("index",   32'(want.index),  32'(got.index));
            check_field("count",   32'(want.count),  32'(got.count));
            check_field("last",    32'(want.last),   32'(got.last));
         end
      end
   end

   // watchdog: ends the run when no beat moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("positional_ordered_list test failed");
      $finish;
   end

   initial begin : run_test
      int total_requests;
      int directed_count;
      bit grow;
      int roll;
      req_kind_type kind;
      data_type v;
      logic [4:0] pos;

      // every input known from the start
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_ADD_FRONT;
      req_ch.value    = '0;
      req_ch.position = '0;
      rsp_ch.ready    = 1'b0;
      gen_count       = 0;
      requests_taken  = 0;
      mismatches      = 0;
      req_gap         = 0;
      rsp_hold        = 0;
      beats_offered   = 0;
      rsp_cycles      = 0;
      req_fired       = 1'b0;
      calm_req        = 1'b0;
      calm_rsp        = 1'b0;
      hold_off_wanted = 1'b0;

      // directed: everything an empty list must refuse
      queue_request(REQ_READ_ALL,  '0, 5'd0);
      queue_request(REQ_DEL_FRONT, '0, 5'd0);
      queue_request(REQ_DEL_BACK,  '0, 5'd0);
      queue_request(REQ_DEL_AT,    '0, 5'd0);
      queue_request(REQ_UPDATE,    32'sd5, 5'd0);
      queue_request(REQ_ADD_AT,    32'sd7, 5'd1);

      // fill to capacity with a mix of insert kinds and extreme values
      for (int i = 0; i < POL_CAPACITY; i++) begin
         case (i)
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = -32'sd1;
            3:       v = '0;
            default: v = $urandom;
         endcase
         case (i % 3)
            0:       queue_request(REQ_ADD_AT, v, 5'(gen_count / 2));
            1:       queue_request(REQ_ADD_FRONT, v, 5'd0);
            default: queue_request(REQ_ADD_BACK, v, 5'd0);
         endcase
      end

      // full list: bad position wins over full, then plain full
      queue_request(REQ_ADD_AT,   32'sd1, 5'd17);
      queue_request(REQ_ADD_AT,   32'sd2, 5'd16);
      queue_request(REQ_ADD_BACK, 32'sd3, 5'd0);
      queue_request(REQ_READ_ALL, '0, 5'd0);
      queue_request(REQ_UPDATE,   32'sd9, 5'd16);
      queue_request(REQ_DEL_AT,   '0, 5'd31);
      queue_request(REQ_DEL_AT,   '0, 5'd15);
      directed_count = request_backlog.size();

      // random part: alternating fill-heavy and drain-heavy stretches so the
      // list keeps swinging between empty and full
      grow = 1'b1;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 35 == 34) grow = ~grow;
         roll = $urandom_range(0, 99);
         if (grow)
            kind = roll < 20 ? REQ_ADD_FRONT : roll < 35 ? REQ_ADD_BACK :
                   roll < 55 ? REQ_ADD_AT    : roll < 68 ? REQ_UPDATE   :
                   roll < 74 ? REQ_DEL_FRONT : roll < 80 ? REQ_DEL_BACK :
                   roll < 88 ? REQ_DEL_AT    : REQ_READ_ALL;
         else
            kind = roll < 7  ? REQ_ADD_FRONT : roll < 14 ? REQ_ADD_BACK :
                   roll < 22 ? REQ_ADD_AT    : roll < 32 ? REQ_UPDATE   :
                   roll < 50 ? REQ_DEL_FRONT : roll < 66 ? REQ_DEL_BACK :
                   roll < 85 ? REQ_DEL_AT    : REQ_READ_ALL;
         case ($urandom_range(0, 9))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = '0;
            3:       v = -32'sd1;
            default: v = $urandom;
         endcase
         // mostly in range, now and then anywhere the field reaches
         if ($urandom_range(0, 6) == 0)
            pos = 5'($urandom_range(0, 31));
         else if (kind == REQ_ADD_AT)
            pos = 5'($urandom_range(0, gen_count));
         else
            pos = (gen_count == 0) ? 5'd0 : 5'($urandom_range(0, gen_count - 1));
         queue_request(kind, v, pos);
      end
      total_requests = request_backlog.size();

      // synchronous reset, released at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // once the random part is under way, ask for the long receiver hold-off
      while (requests_taken < directed_count + 40) @(posedge clock);
      hold_off_wanted = 1'b1;

      while (requests_taken < total_requests) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      // stray beats after the last expected one still get caught here
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("positional_ordered_list test passed");
      else
         $display("positional_ordered_list test failed");
      $finish;
   end

endmodule
